@@ design/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the motor stall detector
// Register map, cause codes, datapath widths and the controller command set.
// ----------------------------------------------------------------------------
package msd_pkg;

    // field widths
    localparam int POS_W     = 32;
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 20;
    localparam int DEV_W     = 16;
    localparam int MINPOS_W  = 31;
    localparam int CAUSE_W   = 2;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SPEED_THRESHOLD    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEVIATION_FRACTION = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_TIME_GAP       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_POSITION       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_FACTOR       = 3'd4;

    localparam logic [SPEED_W-1:0]  RST_SPEED_THRESHOLD    = 20'd0;
    localparam logic [DEV_W-1:0]    RST_DEVIATION_FRACTION = 16'd13107;
    localparam logic [TIME_W-1:0]   RST_MAX_TIME_GAP       = 32'd1000;
    localparam logic [MINPOS_W-1:0] RST_MIN_POSITION       = 31'd0;
    localparam logic [DATA_W-1:0]   RST_SPEED_FACTOR       = 32'd65536;

    // stall causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_MOVE = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_SLOW    = 2'd2;

    // arithmetic
    localparam int SCALE_W      = 10;                      // holds 1000
    localparam logic [SCALE_W-1:0] MS_PER_S = 10'd1000;
    localparam int DIVIDEND_W   = POS_W + SCALE_W;         // diff * 1000
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int Q_W          = DEV_W + 1;               // 65536 - dev
    localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;
    localparam int PROD_W       = SPEED_W + DATA_W;        // motor * factor
    localparam int PART_W       = PROD_W / 2;              // split of the long product
    localparam int PART_PROD_W  = PART_W + Q_W;
    localparam int FULL_W       = PROD_W + Q_W;
    localparam int LIMIT_W      = FULL_W - 32;

    typedef struct packed {
        logic load;   // capture the sample
        logic prep;   // gap, arming, |diff|, motor * factor, 65536 - dev
        logic scale;  // diff * 1000, low partial product
        logic mhi;    // high partial product
        logic step;   // one restoring divide step
        logic fin;    // decide, update stored sample, load result
    } msd_cmd_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed_threshold;
        logic [DEV_W-1:0]    deviation_fraction;
        logic [TIME_W-1:0]   max_time_gap;
        logic [MINPOS_W-1:0] min_position;
        logic [DATA_W-1:0]   speed_factor;
    } msd_cfg_t;

endpackage

@@ design/msd_ctrl.sv @@
// ----------------------------------------------------------------------------
// msd_ctrl: sequencer of the stall detector
// Handshakes both channels and steps the datapath through one sample.
// ----------------------------------------------------------------------------
module msd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output msd_pkg::msd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [msd_pkg::DIV_CNT_W-1:0] LAST_STEP =
        msd_pkg::DIV_CNT_W'(msd_pkg::DIV_STEPS - 1);

    logic [2:0]                    state_reg, state_next;
    logic [msd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                cmd.mhi  = (cnt_reg == '0);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.fin) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/msd_dp.sv @@
// ----------------------------------------------------------------------------
// msd_dp: datapath of the stall detector
// Stored sample, arming checks, serial divider for encoder speed, split
// multiply for the lower speed limit, and the result register.
// ----------------------------------------------------------------------------
module msd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msd_pkg::msd_cmd_t             cmd,
    input  msd_pkg::msd_cfg_t             cfg,
    input  logic [msd_pkg::POS_W-1:0]     s_position,
    input  logic [msd_pkg::TIME_W-1:0]    s_time_ms,
    input  logic [msd_pkg::SPEED_W-1:0]   s_motor_speed,
    output logic                          m_stalled,
    output logic [msd_pkg::CAUSE_W-1:0]   m_stall_cause
);

    localparam int POS_W  = msd_pkg::POS_W;
    localparam int TIME_W = msd_pkg::TIME_W;
    localparam int DVD_W  = msd_pkg::DIVIDEND_W;
    localparam int PART_W = msd_pkg::PART_W;
    localparam int PP_W   = msd_pkg::PART_PROD_W;
    localparam int FULL_W = msd_pkg::FULL_W;
    localparam int LIM_W  = msd_pkg::LIMIT_W;

    // captured sample
    logic [POS_W-1:0]            pos_reg;
    logic [TIME_W-1:0]           now_reg;
    logic [msd_pkg::SPEED_W-1:0] motor_reg;

    // stored sample
    logic [POS_W-1:0]  prev_pos_reg;
    logic [TIME_W-1:0] prev_time_reg;

    // intermediates
    logic [TIME_W-1:0]            gap_reg;
    logic                         armed_reg;
    logic [POS_W-1:0]             diff_reg;
    logic [msd_pkg::PROD_W-1:0]   p_reg;
    logic [msd_pkg::Q_W-1:0]      q_reg;
    logic [DVD_W-1:0]             qn_reg;
    logic [TIME_W-1:0]            rem_reg;
    logic [PP_W-1:0]              prod_lo_reg, prod_hi_reg;

    logic                         stalled_reg;
    logic [msd_pkg::CAUSE_W-1:0]  cause_reg;

    // prep stage
    logic [TIME_W-1:0] gap;
    logic              pos_gt_min;
    logic              armed;
    logic [POS_W:0]    d, d_abs;

    assign gap        = now_reg - prev_time_reg;
    assign pos_gt_min = !pos_reg[POS_W-1] &&
                        (pos_reg[POS_W-2:0] > cfg.min_position);
    assign armed      = (gap != '0) && (gap < cfg.max_time_gap) && pos_gt_min;
    assign d          = {pos_reg[POS_W-1], pos_reg} - {prev_pos_reg[POS_W-1], prev_pos_reg};
    assign d_abs      = d[POS_W] ? ((POS_W+1)'(0) - d) : d;

    // restoring divide step: remainder stays below the gap when the gap is nonzero
    logic [TIME_W:0] trial;
    logic            ge;

    assign trial = {rem_reg, qn_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, gap_reg});

    // decision
    logic [FULL_W-1:0]           full;
    logic [LIM_W-1:0]            limit;
    logic [TIME_W-1:0]           enc_sat;
    logic [TIME_W-1:0]           thr;
    logic                        slow;
    logic [msd_pkg::CAUSE_W-1:0] cause;

    assign full    = (FULL_W'(prod_hi_reg) << PART_W) + FULL_W'(prod_lo_reg);
    assign limit   = full[FULL_W-1 -: LIM_W];
    assign enc_sat = (qn_reg[DVD_W-1:TIME_W] != '0) ? '1 : qn_reg[TIME_W-1:0];
    assign thr     = TIME_W'(cfg.speed_threshold);
    assign slow    = (enc_sat > thr) && (motor_reg > cfg.speed_threshold) &&
                     (LIM_W'(enc_sat) < limit);

    always_comb begin
        priority if (!armed_reg) begin
            cause = msd_pkg::CAUSE_NONE;
        end else if (diff_reg == '0) begin
            cause = msd_pkg::CAUSE_NO_MOVE;
        end else if (slow) begin
            cause = msd_pkg::CAUSE_SLOW;
        end else begin
            cause = msd_pkg::CAUSE_NONE;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg   <= s_position;
            now_reg   <= s_time_ms;
            motor_reg <= s_motor_speed;
        end
        if (cmd.prep) begin
            gap_reg   <= gap;
            armed_reg <= armed;
            diff_reg  <= d_abs[POS_W-1:0];
            p_reg     <= msd_pkg::PROD_W'(motor_reg) * msd_pkg::PROD_W'(cfg.speed_factor);
            q_reg     <= msd_pkg::ONE_Q16 - msd_pkg::Q_W'(cfg.deviation_fraction);
        end
        if (cmd.scale) begin
            qn_reg      <= DVD_W'(diff_reg) * DVD_W'(msd_pkg::MS_PER_S);
            rem_reg     <= '0;
            prod_lo_reg <= PP_W'(p_reg[PART_W-1:0]) * PP_W'(q_reg);
        end
        if (cmd.mhi) begin
            prod_hi_reg <= PP_W'(p_reg[msd_pkg::PROD_W-1:PART_W]) * PP_W'(q_reg);
        end
        if (cmd.step) begin
            rem_reg <= ge ? trial[TIME_W-1:0] - gap_reg : trial[TIME_W-1:0];
            qn_reg  <= {qn_reg[DVD_W-2:0], ge};
        end
        if (cmd.fin) begin
            stalled_reg <= (cause != msd_pkg::CAUSE_NONE);
            cause_reg   <= cause;
        end
    end

    // stored sample, kept on a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg  <= '0;
            prev_time_reg <= '0;
        end else if (cmd.fin && (cause == msd_pkg::CAUSE_NONE)) begin
            prev_pos_reg  <= pos_reg;
            prev_time_reg <= now_reg;
        end
    end

    assign m_stalled     = stalled_reg;
    assign m_stall_cause = cause_reg;

endmodule

@@ design/motor_stall_detector_core.sv @@
// ----------------------------------------------------------------------------
// motor_stall_detector_core: encoder based stall detection, one result per sample
// Register file on the APB port, sequencer and datapath.
// ----------------------------------------------------------------------------
//
//  channel  direction  signals                                      transfer
//  -------  ---------  -------------------------------------------  ---------------
//  s_       in         s_position, s_time_ms, s_motor_speed         s_valid&s_ready
//  m_       out        m_stalled, m_stall_cause                     m_valid&m_ready
//  apb      in/out     psel penable pwrite paddr pwdata prdata      psel&penable
//
//  Sequence per sample: capture, prepare, scale, 42 divider steps for diff*1000/gap,
//  and the decision, which loads the result register.
//  Reset: synchronous, active low; registers return to their defaults and the
//  stored sample to position 0, time 0.
//  Stalls: the result waits in its output register; a new sample is taken while
//  it waits, and only the final decision step holds for a free slot.
//
module motor_stall_detector_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    // sample input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [msd_pkg::POS_W-1:0]         s_position,
    input  logic [msd_pkg::TIME_W-1:0]        s_time_ms,
    input  logic [msd_pkg::SPEED_W-1:0]       s_motor_speed,

    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_stalled,
    output logic [msd_pkg::CAUSE_W-1:0]       m_stall_cause,

    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msd_pkg::ADDR_W-1:0]        paddr,
    input  logic [msd_pkg::DATA_W-1:0]        pwdata,
    output logic [msd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    msd_pkg::msd_cfg_t cfg_reg, cfg_next;
    msd_pkg::msd_cmd_t cmd;

    logic                             wr_en;
    logic [msd_pkg::REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // registers sit on word addresses
    assign reg_idx = paddr[msd_pkg::ADDR_W-1:2];

    // write decode: only the register's own width is kept, other indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                msd_pkg::REG_SPEED_THRESHOLD:
                    cfg_next.speed_threshold = pwdata[msd_pkg::SPEED_W-1:0];
                msd_pkg::REG_DEVIATION_FRACTION:
                    cfg_next.deviation_fraction = pwdata[msd_pkg::DEV_W-1:0];
                msd_pkg::REG_MAX_TIME_GAP:
                    cfg_next.max_time_gap = pwdata;
                msd_pkg::REG_MIN_POSITION:
                    cfg_next.min_position = pwdata[msd_pkg::MINPOS_W-1:0];
                msd_pkg::REG_SPEED_FACTOR:
                    cfg_next.speed_factor = pwdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_threshold    <= msd_pkg::RST_SPEED_THRESHOLD;
            cfg_reg.deviation_fraction <= msd_pkg::RST_DEVIATION_FRACTION;
            cfg_reg.max_time_gap       <= msd_pkg::RST_MAX_TIME_GAP;
            cfg_reg.min_position       <= msd_pkg::RST_MIN_POSITION;
            cfg_reg.speed_factor       <= msd_pkg::RST_SPEED_FACTOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, zero outside the map
    always_comb begin
        unique case (reg_idx)
            msd_pkg::REG_SPEED_THRESHOLD:
                prdata = msd_pkg::DATA_W'(cfg_reg.speed_threshold);
            msd_pkg::REG_DEVIATION_FRACTION:
                prdata = msd_pkg::DATA_W'(cfg_reg.deviation_fraction);
            msd_pkg::REG_MAX_TIME_GAP:
                prdata = cfg_reg.max_time_gap;
            msd_pkg::REG_MIN_POSITION:
                prdata = msd_pkg::DATA_W'(cfg_reg.min_position);
            msd_pkg::REG_SPEED_FACTOR:
                prdata = cfg_reg.speed_factor;
            default:
                prdata = '0;
        endcase
    end

    // sequencer: owns both handshakes and the divide step count
    msd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: stored sample, divider, limit multiply, result register
    msd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .s_position    (s_position),
        .s_time_ms     (s_time_ms),
        .s_motor_speed (s_motor_speed),
        .m_stalled     (m_stalled),
        .m_stall_cause (m_stall_cause)
    );

endmodule
